// ===== src/hsfd_pkg.sv =====
// hsfd_pkg: shared types, constants and the crc-8 step function for the
// humidity sensor frame decoder; no dependencies
package hsfd_pkg;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam int TEMP_PROD_W = 31;
    localparam int HUM_PROD_W  = 30;

    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [13:0] HUM_SPAN    = 14'd10000;
    localparam logic [15:0] FULL_SCALE  = 16'hFFFF;
    localparam logic [14:0] HALF_SCALE  = 15'd32767;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;

    localparam logic signed [14:0] MIN_TEMP_RESET = -15'sd2000;
    localparam logic signed [14:0] MAX_TEMP_RESET = 15'sd12500;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_CRC_ERROR    = 2'd1,
        STATUS_OUT_OF_RANGE = 2'd2
    } status_t;

    // one complete frame handed from front to back
    typedef struct packed {
        logic [15:0] temp_raw;
        logic [15:0] hum_raw;
        logic        bad;
    } job_t;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [13:0]        humidity_centi;
        status_t            frame_status;
    } result_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] r;
        r = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

endpackage

// ===== src/hsfd_fifo.sv =====
// hsfd_fifo: small register queue, first word fall-through
// no package dependencies
module hsfd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wr_data,
    output logic                       full,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rd_data,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/hsfd_front.sv =====
// hsfd_front: takes frame bytes, tracks position, runs the crc-8 check and
// assembles the raw words; depends on hsfd_pkg
module hsfd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    rx_byte,
    input  logic          frame_start,
    input  logic          job_full,
    output logic          job_push,
    output hsfd_pkg::job_t job_data
);

    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    logic [2:0]  pos_reg,      pos_next;
    logic [7:0]  crc_reg,      crc_next;
    logic [15:0] temp_raw_reg, temp_raw_next;
    logic [15:0] hum_raw_reg,  hum_raw_next;
    logic        failed_reg,   failed_next;

    logic [2:0]  pos;
    logic [7:0]  crc_base;
    logic        failed_base;

    always_comb
    begin
        pos         = (frame_start || pos_reg > POS_H_CRC) ? POS_T_HI : pos_reg;
        crc_base    = (pos == POS_T_HI) ? hsfd_pkg::CRC_INIT : crc_reg;
        failed_base = (pos == POS_T_HI) ? 1'b0 : failed_reg;

        pos_next      = pos_reg;
        crc_next      = crc_reg;
        temp_raw_next = temp_raw_reg;
        hum_raw_next  = hum_raw_reg;
        failed_next   = failed_reg;
        job_push      = 1'b0;

        if (accept)
        begin
            pos_next    = pos + 3'd1;
            crc_next    = crc_base;
            failed_next = failed_base;
            case (pos)
                POS_T_HI, POS_T_LO:
                begin
                    temp_raw_next = {temp_raw_reg[7:0], rx_byte};
                    crc_next      = hsfd_pkg::crc8_update(crc_base, rx_byte);
                end
                POS_T_CRC:
                begin
                    failed_next = failed_base || (crc_base != rx_byte);
                    crc_next    = hsfd_pkg::CRC_INIT;
                end
                POS_H_HI, POS_H_LO:
                begin
                    hum_raw_next = {hum_raw_reg[7:0], rx_byte};
                    crc_next     = hsfd_pkg::crc8_update(crc_base, rx_byte);
                end
                default:
                begin
                    // last byte closes the frame
                    pos_next    = POS_T_HI;
                    crc_next    = hsfd_pkg::CRC_INIT;
                    failed_next = 1'b0;
                    job_push    = 1'b1;
                end
            endcase
        end
    end

    assign job_data.temp_raw = temp_raw_reg;
    assign job_data.hum_raw  = hum_raw_reg;
    assign job_data.bad      = failed_base || (crc_base != rx_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= POS_T_HI;
            crc_reg      <= hsfd_pkg::CRC_INIT;
            temp_raw_reg <= '0;
            hum_raw_reg  <= '0;
            failed_reg   <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            temp_raw_reg <= temp_raw_next;
            hum_raw_reg  <= hum_raw_next;
            failed_reg   <= failed_next;
        end
    end

    a_pos_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_H_CRC)
        else $error("frame position out of range");

    a_job_room: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !job_full)
        else $error("frame job pushed into full queue");

endmodule

// ===== src/hsfd_back.sv =====
// hsfd_back: three-stage scaling pipeline (multiply, divide by full scale
// with rounding, range check); depends on hsfd_pkg
module hsfd_back #(
    parameter int OUT_DEPTH = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           job_empty,
    input  hsfd_pkg::job_t                 job_data,
    output logic                           job_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
    input  logic signed [14:0]             min_temp,
    input  logic signed [14:0]             max_temp,
    output logic                           res_push,
    output hsfd_pkg::result_t              res_data
);

    localparam int CW = $clog2(OUT_DEPTH+1);
    localparam int TW = hsfd_pkg::TEMP_PROD_W;
    localparam int HW = hsfd_pkg::HUM_PROD_W;

    logic          v1_reg, v2_reg, v3_reg;
    logic [TW-1:0] t_prod_reg;
    logic [HW-1:0] h_prod_reg;
    logic          bad1_reg, bad2_reg;
    logic [14:0]   temp2_reg;
    logic [13:0]   hum2_reg;
    hsfd_pkg::result_t res3_reg;

    logic [1:0]    inflight;
    logic [CW:0]   occupancy;
    logic [TW-1:0] t_sum;
    logic [16:0]   t_fold;
    logic [14:0]   t_q;
    logic [HW-1:0] h_sum;
    logic [16:0]   h_fold;
    logic [13:0]   h_q;
    logic signed [14:0] temp2;
    logic          in_range;

    // credit: never start more than the output queue can still hold
    assign inflight  = 2'(v1_reg) + 2'(v2_reg) + 2'(v3_reg);
    assign occupancy = (CW+1)'(out_count) + (CW+1)'(inflight);
    assign job_pop   = !job_empty && (occupancy < (CW+1)'(OUT_DEPTH));

    // x / 65535 = hi + correction, since x - hi*65535 = lo + hi < 2*65535
    always_comb
    begin
        t_sum  = t_prod_reg + TW'(hsfd_pkg::HALF_SCALE);
        t_fold = {1'b0, t_sum[15:0]} + 17'(t_sum[TW-1:16]);
        t_q    = 15'(t_sum[TW-1:16]) + 15'(t_fold >= 17'(hsfd_pkg::FULL_SCALE));
        h_sum  = h_prod_reg + HW'(hsfd_pkg::HALF_SCALE);
        h_fold = {1'b0, h_sum[15:0]} + 17'(h_sum[HW-1:16]);
        h_q    = 14'(h_sum[HW-1:16]) + 14'(h_fold >= 17'(hsfd_pkg::FULL_SCALE));
    end

    assign temp2    = $signed(temp2_reg);
    assign in_range = (temp2 >= min_temp) && (temp2 <= max_temp);

    always_ff @(posedge clk)
    begin
        t_prod_reg <= TW'(job_data.temp_raw) * TW'(hsfd_pkg::TEMP_SPAN);
        h_prod_reg <= HW'(job_data.hum_raw) * HW'(hsfd_pkg::HUM_SPAN);
        bad1_reg   <= job_data.bad;

        temp2_reg <= t_q - hsfd_pkg::TEMP_OFFSET;
        hum2_reg  <= h_q;
        bad2_reg  <= bad1_reg;

        if (bad2_reg)
        begin
            res3_reg.temperature_centi <= '0;
            res3_reg.humidity_centi    <= '0;
            res3_reg.frame_status      <= hsfd_pkg::STATUS_CRC_ERROR;
        end
        else
        begin
            res3_reg.temperature_centi <= temp2;
            res3_reg.humidity_centi    <= hum2_reg;
            res3_reg.frame_status      <= in_range ? hsfd_pkg::STATUS_OK
                                                   : hsfd_pkg::STATUS_OUT_OF_RANGE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= job_pop;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign res_push = v3_reg;
    assign res_data = res3_reg;

    a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (out_count < CW'(OUT_DEPTH)))
        else $error("result pushed into full output queue");

    a_crc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_data.frame_status == hsfd_pkg::STATUS_CRC_ERROR) |->
        (res_data.temperature_centi == '0 && res_data.humidity_centi == '0))
        else $error("crc error result carries nonzero values");

    a_hum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (res_data.humidity_centi <= hsfd_pkg::HUM_SPAN))
        else $error("humidity above full scale");

endmodule

// ===== src/humidity_sensor_frame_decoder.sv =====
// humidity_sensor_frame_decoder: top level; one byte item per cycle, front
// never waits on the scaling pipeline except when the job queue is full
// a result reaches the output queue after its sixth byte is accepted, passing
// through the job queue, then the multiply, divide and range-check stages
// throughput: one byte per cycle while the job queue is not full, one result per six-byte frame
// reset: position 0, crc 0xFF, limits -2000 and 12500, both queues empty
module humidity_sensor_frame_decoder #(
    parameter int JOB_DEPTH = 2,
    parameter int OUT_DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         rx_byte,
    input  logic               frame_start,
    output logic               empty,
    input  logic               pop,
    output logic signed [14:0] temperature_centi,
    output logic [13:0]        humidity_centi,
    output logic [1:0]         frame_status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int JW = $bits(hsfd_pkg::job_t);
    localparam int RW = $bits(hsfd_pkg::result_t);
    localparam logic REG_MIN_TEMP = 1'b0;
    localparam logic REG_MAX_TEMP = 1'b1;

    logic signed [14:0] min_temp_reg;
    logic signed [14:0] max_temp_reg;
    logic               cfg_write;

    logic               accept;
    logic               job_push;
    logic               job_full;
    logic               job_empty;
    logic               job_pop;
    hsfd_pkg::job_t     job_in;
    logic [JW-1:0]      job_out_bits;
    logic [$clog2(JOB_DEPTH+1)-1:0] job_count;

    logic               res_push;
    hsfd_pkg::result_t  res_in;
    hsfd_pkg::result_t  res_out;
    logic [RW-1:0]      res_out_bits;
    logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
    logic               out_full;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_MAX_TEMP) ? 32'(max_temp_reg) : 32'(min_temp_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_temp_reg <= hsfd_pkg::MIN_TEMP_RESET;
            max_temp_reg <= hsfd_pkg::MAX_TEMP_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_MIN_TEMP)
            begin
                min_temp_reg <= $signed(pwdata[14:0]);
            end
            else
            begin
                max_temp_reg <= $signed(pwdata[14:0]);
            end
        end
    end

    assign full   = job_full;
    assign accept = push && !full;

    hsfd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (rx_byte),
        .frame_start (frame_start),
        .job_full    (job_full),
        .job_push    (job_push),
        .job_data    (job_in)
    );

    hsfd_fifo #(
        .WIDTH (JW),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_push),
        .wr_data (job_in),
        .full    (job_full),
        .pop     (job_pop),
        .rd_data (job_out_bits),
        .empty   (job_empty),
        .count   (job_count)
    );

    hsfd_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job_data  (hsfd_pkg::job_t'(job_out_bits)),
        .job_pop   (job_pop),
        .out_count (out_count),
        .min_temp  (min_temp_reg),
        .max_temp  (max_temp_reg),
        .res_push  (res_push),
        .res_data  (res_in)
    );

    hsfd_fifo #(
        .WIDTH (RW),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (out_full),
        .pop     (pop),
        .rd_data (res_out_bits),
        .empty   (empty),
        .count   (out_count)
    );

    assign res_out           = hsfd_pkg::result_t'(res_out_bits);
    assign temperature_centi = res_out.temperature_centi;
    assign humidity_centi    = res_out.humidity_centi;
    assign frame_status      = res_out.frame_status;

    a_job_count: assert property (@(posedge clk) disable iff (!rst_n)
        job_full |-> (job_count == ($clog2(JOB_DEPTH+1))'(JOB_DEPTH)))
        else $error("job queue full flag disagrees with count");

    a_out_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !out_full)
        else $error("output queue overflow");

endmodule
